// ===== rtl/core/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, codes and constants of the IR pulse-distance frame decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    // Number of data bits in one frame after the preamble.
    localparam int FRAME_BITS = 32;
    localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);

    // Field widths.
    localparam int TIME_W     = 32;
    localparam int NOMINAL_W  = 16;
    localparam int TOL_W      = 12;
    localparam int TIMEOUT_W  = 20;
    localparam int BOUND_W    = NOMINAL_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd5;

    // Configuration reset values.
    localparam logic [NOMINAL_W-1:0] PREAMBLE_RST  = 16'd13500;
    localparam logic [NOMINAL_W-1:0] ZERO_RST      = 16'd1125;
    localparam logic [NOMINAL_W-1:0] ONE_RST       = 16'd2250;
    localparam logic [NOMINAL_W-1:0] REPEAT_RST    = 16'd11250;
    localparam logic [TOL_W-1:0]     TOLERANCE_RST = 12'd100;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 20'd20000;

    // Request kinds.
    localparam logic REQ_EDGE   = 1'b0;
    localparam logic REQ_RESUME = 1'b1;

    // Complement check value.
    localparam logic [7:0] BYTE_ALL_ONES = 8'hff;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_NONE           = 3'd0,
        ST_OK             = 3'd1,
        ST_BAD_INTERVAL   = 3'd2,
        ST_PREAMBLE_MID   = 3'd3,
        ST_BIT_EARLY      = 3'd4,
        ST_BAD_COMPLEMENT = 3'd5
    } status_t;

    // Interval classes.
    typedef enum logic [2:0] {
        K_PREAMBLE = 3'd0,
        K_ZERO     = 3'd1,
        K_ONE      = 3'd2,
        K_REPEAT   = 3'd3,
        K_ERROR    = 3'd4
    } kind_t;

    // Configuration register set.
    typedef struct packed {
        logic [NOMINAL_W-1:0] preamble_us;
        logic [NOMINAL_W-1:0] zero_us;
        logic [NOMINAL_W-1:0] one_us;
        logic [NOMINAL_W-1:0] repeat_us;
        logic [TOL_W-1:0]     tolerance_us;
        logic [TIMEOUT_W-1:0] timeout_us;
    } cfg_t;

    // Result of one request step.
    typedef struct packed {
        status_t             status;
        logic [TIME_W-1:0]   frame_word;
        logic                halted;
    } result_t;

endpackage

// ===== rtl/core/irpd_if.sv =====
// ----------------------------------------------------------------------------
// irpd_if
// Valid/ready channels for requests into and results out of the decoder.
// ----------------------------------------------------------------------------
interface irpd_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] edge_time_us;

    modport source (output valid, output req_type, output edge_time_us, input ready);
    modport sink   (input valid, input req_type, input edge_time_us, output ready);
endinterface

interface irpd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] frame_word;
    logic [7:0]  address_byte;
    logic [7:0]  command_byte;
    logic        halted;

    modport source (
        output valid, output status, output frame_word, output address_byte,
        output command_byte, output halted, input ready
    );
    modport sink (
        input valid, input status, input frame_word, input address_byte,
        input command_byte, input halted, output ready
    );
endinterface

// ===== rtl/core/irpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// irpd_cfg_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module irpd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output irpd_pkg::cfg_t                    cfg
);
    import irpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and replace the addressed field.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PREAMBLE:  cfg_next.preamble_us  = cfg_data[NOMINAL_W-1:0];
                REG_ZERO:      cfg_next.zero_us      = cfg_data[NOMINAL_W-1:0];
                REG_ONE:       cfg_next.one_us       = cfg_data[NOMINAL_W-1:0];
                REG_REPEAT:    cfg_next.repeat_us    = cfg_data[NOMINAL_W-1:0];
                REG_TOLERANCE: cfg_next.tolerance_us = cfg_data[TOL_W-1:0];
                REG_TIMEOUT:   cfg_next.timeout_us   = cfg_data[TIMEOUT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_us  <= PREAMBLE_RST;
            cfg_reg.zero_us      <= ZERO_RST;
            cfg_reg.one_us       <= ONE_RST;
            cfg_reg.repeat_us    <= REPEAT_RST;
            cfg_reg.tolerance_us <= TOLERANCE_RST;
            cfg_reg.timeout_us   <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/irpd_classify.sv =====
// ----------------------------------------------------------------------------
// irpd_classify
// Sorts an edge-to-edge interval into preamble, zero, one, repeat or error.
// ----------------------------------------------------------------------------
module irpd_classify (
    input  logic [irpd_pkg::TIME_W-1:0] interval,
    input  irpd_pkg::cfg_t              cfg,
    output irpd_pkg::kind_t             kind
);
    import irpd_pkg::*;

    // True when t lies within nominal +/- tolerance; the low bound stops at 0.
    function automatic logic in_window(
        input logic [TIME_W-1:0]    t,
        input logic [NOMINAL_W-1:0] nominal,
        input logic [TOL_W-1:0]     tol
    );
        logic [NOMINAL_W-1:0] lo;
        logic [BOUND_W-1:0]   hi;
        lo = (nominal >= NOMINAL_W'(tol)) ? nominal - NOMINAL_W'(tol) : '0;
        hi = BOUND_W'(nominal) + BOUND_W'(tol);
        return (t >= TIME_W'(lo)) && (t <= TIME_W'(hi));
    endfunction

    logic [BOUND_W-1:0] preamble_hi;

    assign preamble_hi = BOUND_W'(cfg.preamble_us) + BOUND_W'(cfg.tolerance_us);

    // Windows are tried in a fixed order; the first match wins.
    always_comb
    begin
        priority if (interval > TIME_W'(preamble_hi))
            kind = K_ERROR;
        else if (in_window(interval, cfg.preamble_us, cfg.tolerance_us))
            kind = K_PREAMBLE;
        else if (in_window(interval, cfg.zero_us, cfg.tolerance_us))
            kind = K_ZERO;
        else if (in_window(interval, cfg.one_us, cfg.tolerance_us))
            kind = K_ONE;
        else if (in_window(interval, cfg.repeat_us, cfg.tolerance_us))
            kind = K_REPEAT;
        else
            kind = K_ERROR;
    end

endmodule

// ===== rtl/core/irpd_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// irpd_frame_ctrl
// Frame reception state and its one-request update step.
// ----------------------------------------------------------------------------
module irpd_frame_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  logic                         req_type,
    input  logic [irpd_pkg::TIME_W-1:0]  edge_time_us,
    input  irpd_pkg::cfg_t               cfg,
    output irpd_pkg::result_t            result
);
    import irpd_pkg::*;

    logic [TIME_W-1:0]    last_edge_reg,     last_edge_next;
    logic                 have_last_reg,     have_last_next;
    logic                 started_reg,       started_next;
    logic [BIT_CNT_W-1:0] bit_count_reg,     bit_count_next;
    logic [TIME_W-1:0]    shift_word_reg,    shift_word_next;
    logic                 paused_reg,        paused_next;

    logic [TIME_W-1:0]    interval;
    kind_t                kind;
    logic [TIME_W-1:0]    shifted;
    logic [BIT_CNT_W-1:0] count_inc;
    logic                 complement_ok;
    status_t              status;

    // Interval since the previous edge, modulo 2^32.
    assign interval = edge_time_us - last_edge_reg;

    irpd_classify u_classify (
        .interval (interval),
        .cfg      (cfg),
        .kind     (kind)
    );

    // Candidate values for a data bit.
    assign shifted   = {shift_word_reg[TIME_W-2:0], (kind == K_ONE)};
    assign count_inc = bit_count_reg + BIT_CNT_W'(1);
    assign complement_ok = ((shifted[7:0] ^ shifted[15:8]) == BYTE_ALL_ONES)
                        && ((shifted[23:16] ^ shifted[31:24]) == BYTE_ALL_ONES);

    // Next state and status for the current request.
    always_comb
    begin
        last_edge_next  = last_edge_reg;
        have_last_next  = have_last_reg;
        started_next    = started_reg;
        bit_count_next  = bit_count_reg;
        shift_word_next = shift_word_reg;
        paused_next     = paused_reg;
        status          = ST_NONE;

        if (req_type == REQ_RESUME)
        begin
            started_next    = 1'b0;
            bit_count_next  = '0;
            shift_word_next = '0;
            paused_next     = 1'b0;
        end
        else if (paused_reg)
        begin
            status = ST_NONE;
        end
        else if (!have_last_reg)
        begin
            have_last_next = 1'b1;
            last_edge_next = edge_time_us;
        end
        else
        begin
            last_edge_next = edge_time_us;
            if (interval > TIME_W'(cfg.timeout_us))
            begin
                started_next    = 1'b0;
                bit_count_next  = '0;
                shift_word_next = '0;
            end
            else if (interval != '0)
            begin
                unique case (kind)
                    K_ERROR:
                    begin
                        paused_next = 1'b1;
                        status      = ST_BAD_INTERVAL;
                    end
                    K_REPEAT:
                    begin
                        status = ST_NONE;
                    end
                    K_PREAMBLE:
                    begin
                        if (started_reg)
                        begin
                            paused_next = 1'b1;
                            status      = ST_PREAMBLE_MID;
                        end
                        else
                        begin
                            started_next   = 1'b1;
                            bit_count_next = '0;
                        end
                    end
                    K_ZERO, K_ONE:
                    begin
                        if (!started_reg)
                        begin
                            paused_next = 1'b1;
                            status      = ST_BIT_EARLY;
                        end
                        else
                        begin
                            shift_word_next = shifted;
                            bit_count_next  = count_inc;
                            if (count_inc == BIT_CNT_W'(FRAME_BITS))
                            begin
                                paused_next = 1'b1;
                                status      = complement_ok ? ST_OK : ST_BAD_COMPLEMENT;
                            end
                        end
                    end
                    default:
                    begin
                        status = ST_NONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg  <= '0;
            have_last_reg  <= 1'b0;
            started_reg    <= 1'b0;
            bit_count_reg  <= '0;
            shift_word_reg <= '0;
            paused_reg     <= 1'b1;
        end
        else if (step_en)
        begin
            last_edge_reg  <= last_edge_next;
            have_last_reg  <= have_last_next;
            started_reg    <= started_next;
            bit_count_reg  <= bit_count_next;
            shift_word_reg <= shift_word_next;
            paused_reg     <= paused_next;
        end
    end

    assign result.status     = status;
    assign result.frame_word = shift_word_next;
    assign result.halted     = paused_next;

endmodule

// ===== rtl/core/ir_pulse_distance_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Pulse-distance IR remote frame decoder working on edge timestamps.
// ----------------------------------------------------------------------------
// Each request is either a falling-edge timestamp in microseconds or a resume
// command, and each request yields exactly one result carrying the status,
// the current frame word with its address and command bytes, and the halted
// flag. The block takes one request per clock cycle while results are taken:
// a request is captured in an input register, the frame state is updated and
// the result is formed in a single step of compare logic, and the result is
// held in an output register. The output register decouples the two sides; a
// stalled result holds the input stage, and requests keep flowing as long as
// results are taken. After reset the decoder is halted and ignores edges
// until a resume request arrives. Configuration registers must be written
// only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    irpd_in_if.sink                           in_req,
    irpd_out_if.source                        out_rsp
);
    import irpd_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic              in_valid_reg,  in_valid_next;
    logic              in_type_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg;
    logic              advance;
    logic              in_take;

    irpd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    irpd_frame_ctrl u_frame_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .req_type     (in_type_reg),
        .edge_time_us (in_time_reg),
        .cfg          (cfg),
        .result       (result)
    );

    // Pipeline handshake: the held request moves on when the output is free.
    assign advance      = in_valid_reg && (!out_valid_reg || out_rsp.ready);
    assign in_req.ready = !in_valid_reg || advance;
    assign in_take      = in_req.valid && in_req.ready;

    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_rsp.ready ? 1'b0 : out_valid_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_type_reg <= in_req.req_type;
            in_time_reg <= in_req.edge_time_us;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_rsp.valid        = out_valid_reg;
    assign out_rsp.status       = out_data_reg.status;
    assign out_rsp.frame_word   = out_data_reg.frame_word;
    assign out_rsp.address_byte = out_data_reg.frame_word[31:24];
    assign out_rsp.command_byte = out_data_reg.frame_word[15:8];
    assign out_rsp.halted       = out_data_reg.halted;

endmodule
